### src/assert_macros.svh
// Assertion helpers shared by the candidate pool modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/scp_pkg.sv
package scp_pkg;

  localparam int POOL_DEPTH   = 64;
  localparam int ID_BITS      = 24;
  localparam int DIST_BITS    = 32;
  localparam int IDX_BITS     = $clog2(POOL_DEPTH);
  localparam int POS_BITS     = 6;
  localparam int SIZE_BITS    = 7;
  localparam int CAND_ID_BITS = 24;

  localparam logic [SIZE_BITS-1:0] RESET_POOL_SIZE = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_TAKE   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    op_t                          operation;
    logic [CAND_ID_BITS-1:0]      cand_id;
    logic signed [DIST_BITS-1:0]  cand_dist;
    logic [POS_BITS-1:0]          read_index;
  } in_item_t;

  typedef struct packed {
    logic                         accepted;
    logic [POS_BITS-1:0]          insert_pos;
    logic                         found;
    logic [CAND_ID_BITS-1:0]      out_id;
    logic signed [DIST_BITS-1:0]  out_dist;
    logic [POS_BITS-1:0]          out_pos;
  } out_item_t;

  typedef struct packed {
    logic                         valid;
    logic                         unexp;
    logic [ID_BITS-1:0]           id;
    logic signed [DIST_BITS-1:0]  distance;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic apply;
    op_t  op;
    logic ins_ok;
  } cell_ctl_t;

endpackage

### src/scp_cell.sv
`include "assert_macros.svh"

module scp_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  scp_pkg::cell_ctl_t                    ctl,
  input  logic [scp_pkg::ID_BITS-1:0]           cand_id,
  input  logic signed [scp_pkg::DIST_BITS-1:0]  cand_dist,
  input  logic                                  sel,
  input  scp_pkg::entry_t                       prev,
  input  logic                                  prev_le,
  output scp_pkg::entry_t                       entry,
  output logic                                  le,
  output logic                                  eq,
  output logic                                  take
);
  import scp_pkg::*;

  logic                        valid;
  logic                        unexp;
  logic [ID_BITS-1:0]          id;
  logic signed [DIST_BITS-1:0] distance;
  entry_t                      entry_next;
  logic                        le_next;
  logic                        eq_next;

  assign entry = '{valid: valid, unexp: unexp, id: id, distance: distance};

  assign le_next = valid && en && (distance <= cand_dist);
  assign eq_next = valid && en && (distance == cand_dist) && (id == cand_id);
  assign take    = en && !le && prev_le;

  always_comb begin
    entry_next = entry;
    if (ctl.apply) begin
      priority if (!en || ctl.op == OP_CLEAR) begin
        entry_next.valid = 1'b0;
        entry_next.unexp = 1'b0;
      end else if (ctl.op == OP_INSERT && ctl.ins_ok && !le) begin
        if (prev_le) begin
          entry_next.valid    = 1'b1;
          entry_next.unexp    = 1'b1;
          entry_next.id       = cand_id;
          entry_next.distance = cand_dist;
        end else begin
          entry_next = prev;
        end
      end else if (ctl.op == OP_TAKE && sel) begin
        entry_next.unexp = 1'b0;
      end else begin
        entry_next = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      unexp <= 1'b0;
      le    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      valid <= entry_next.valid;
      unexp <= entry_next.unexp;
      if (ctl.capture) begin
        le <= le_next;
        eq <= eq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    id       <= entry_next.id;
    distance <= entry_next.distance;
  end

  `SCP_ASSERT_IMP(a_unexp_needs_valid, clk, rst, unexp, valid, "unexpanded flag on an empty cell")
  `SCP_ASSERT_IMP(a_sorted, clk, rst, valid && prev.valid, prev.distance <= distance, "pool order broken")

endmodule

### src/sorted_candidate_pool.sv
// A result is registered when its item is applied (ST_APPLY) after its transfer (ST_IDLE).
// Apply waits while the result side stalls; no new item is taken until the last is applied.
// Each item is compared in every cell at its transfer, then applied to all cells at once.
// The next item is taken as soon as the previous result is loaded into the output register.
// Reset empties the pool and sets the beam width to 64; no clearing pass is needed.
`include "assert_macros.svh"

module sorted_candidate_pool (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  scp_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output scp_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scp_pkg::SIZE_BITS-1:0]   cfg_data
);
  import scp_pkg::*;

  state_t                      state;
  state_t                      state_next;
  logic [SIZE_BITS-1:0]        beam_width;
  in_item_t                    req;
  cell_ctl_t                   ctl;
  logic                        accept;
  logic                        fire;
  logic                        dup;
  logic                        drop;
  logic                        ins_ok;
  logic [ID_BITS-1:0]          cand_id;
  logic signed [DIST_BITS-1:0] cand_dist;
  logic [POOL_DEPTH-1:0]       sel;
  logic [POOL_DEPTH-1:0]       sel_next;
  logic [POOL_DEPTH-1:0]       en;
  logic [POOL_DEPTH-1:0]       tail;
  logic [POOL_DEPTH-1:0]       le_vec;
  logic [POOL_DEPTH-1:0]       eq_vec;
  logic [POOL_DEPTH-1:0]       take_vec;
  logic [POOL_DEPTH-1:0]       valid_vec;
  logic [POOL_DEPTH-1:0]       un_vec;
  logic [POOL_DEPTH-1:0]       rd_hit;
  logic [POOL_DEPTH-1:0]       prev_le;
  entry_t                      cell_entry [POOL_DEPTH];
  entry_t                      prev_entry [POOL_DEPTH];
  logic [IDX_BITS-1:0]         ins_idx;
  logic [IDX_BITS-1:0]         sel_idx;
  logic [ID_BITS-1:0]          sel_id;
  logic signed [DIST_BITS-1:0] sel_dist;
  logic                        sel_any;
  out_item_t                   res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_width <= RESET_POOL_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      beam_width <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (fire) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall     = (state != ST_IDLE);
    accept         = item_valid && (state == ST_IDLE);
    fire           = (state == ST_APPLY) && (!result_valid || !result_stall);
    ctl.capture    = accept;
    ctl.apply      = fire;
    ctl.op         = req.operation;
    ctl.ins_ok     = ins_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cand_id   = (state == ST_IDLE) ? ID_BITS'(item.cand_id) : ID_BITS'(req.cand_id);
  assign cand_dist = (state == ST_IDLE) ? item.cand_dist : req.cand_dist;

  for (genvar gi = 0; gi < POOL_DEPTH; gi++) begin : g_cell
    assign en[gi]        = (gi == 0) || (32'(beam_width) > gi);
    assign valid_vec[gi] = cell_entry[gi].valid;
    assign un_vec[gi]    = cell_entry[gi].valid && cell_entry[gi].unexp && en[gi];
    assign rd_hit[gi]    = (32'(item.read_index) == gi) && cell_entry[gi].valid && en[gi];

    if (gi == POOL_DEPTH - 1) begin : g_last
      assign tail[gi] = en[gi];
    end else begin : g_mid
      assign tail[gi] = en[gi] && !en[gi+1];
    end

    if (gi == 0) begin : g_head
      assign prev_entry[gi] = '0;
      assign prev_le[gi]    = 1'b1;
    end else begin : g_link
      assign prev_entry[gi] = cell_entry[gi-1];
      assign prev_le[gi]    = le_vec[gi-1];
    end

    scp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en[gi]),
      .ctl       (ctl),
      .cand_id   (cand_id),
      .cand_dist (cand_dist),
      .sel       (sel[gi]),
      .prev      (prev_entry[gi]),
      .prev_le   (prev_le[gi]),
      .entry     (cell_entry[gi]),
      .le        (le_vec[gi]),
      .eq        (eq_vec[gi]),
      .take      (take_vec[gi])
    );
  end

  assign sel_next = (item.operation == OP_TAKE) ?
                    (un_vec & (~un_vec + POOL_DEPTH'(1))) : rd_hit;

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item;
      sel <= sel_next;
    end
  end

  always_comb begin
    dup      = |eq_vec;
    drop     = |(tail & le_vec);
    ins_ok   = !dup && !drop;
    sel_any  = |sel;
    ins_idx  = '0;
    sel_idx  = '0;
    sel_id   = '0;
    sel_dist = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (take_vec[i]) ins_idx = ins_idx | IDX_BITS'(i);
      if (sel[i]) begin
        sel_idx  = sel_idx | IDX_BITS'(i);
        sel_id   = sel_id | cell_entry[i].id;
        sel_dist = sel_dist | cell_entry[i].distance;
      end
    end
  end

  always_comb begin
    res_next = '0;
    unique case (req.operation)
      OP_CLEAR: begin
        res_next = '0;
      end
      OP_INSERT: begin
        res_next.accepted   = ins_ok;
        res_next.insert_pos = ins_ok ? POS_BITS'(ins_idx) : '0;
      end
      OP_TAKE, OP_READ: begin
        res_next.found    = sel_any;
        res_next.out_id   = CAND_ID_BITS'(sel_id);
        res_next.out_dist = sel_dist;
        res_next.out_pos  = POS_BITS'(sel_idx);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  `SCP_ASSERT_NXT(a_result_from_apply, clk, rst, (state != ST_APPLY) && !result_valid, !result_valid, "result appeared without an applied item")
  `SCP_ASSERT_IMP(a_valid_prefix, clk, rst, 1'b1, (valid_vec & (valid_vec + POOL_DEPTH'(1))) == '0, "occupied cells are not contiguous")
  `SCP_ASSERT_IMP(a_sel_onehot, clk, rst, state == ST_APPLY, $onehot0(sel), "more than one cell selected")

endmodule
